[sv/reliable_delivery_retry_tracker_macros.svh]
// Assertion macros for the retry tracker.
`ifndef RELIABLE_DELIVERY_RETRY_TRACKER_MACROS_SVH
`define RELIABLE_DELIVERY_RETRY_TRACKER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RDRT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define RDRT_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define RDRT_ASSERT(label, clk, rst_n, prop)
`define RDRT_ASSERT_RST(label, clk, prop)
`endif
`endif

[sv/rdrt_pkg.sv]
// Shared types and codes for the retry tracker.
package rdrt_pkg;
    localparam logic [2:0] FUNC_START = 3'd0;
    localparam logic [2:0] FUNC_SEND  = 3'd1;
    localparam logic [2:0] FUNC_TICK  = 3'd2;
    localparam logic [2:0] FUNC_ACK   = 3'd3;
    localparam logic [2:0] FUNC_PONG  = 3'd4;
    localparam logic [2:0] FUNC_PING  = 3'd5;
    localparam logic [2:0] FUNC_DATA  = 3'd6;

    localparam logic [3:0] KIND_SEND    = 4'd0;
    localparam logic [3:0] KIND_RESEND  = 4'd1;
    localparam logic [3:0] KIND_ACK     = 4'd2;
    localparam logic [3:0] KIND_PONG    = 4'd3;
    localparam logic [3:0] KIND_DELIVER = 4'd4;
    localparam logic [3:0] KIND_ACKED   = 4'd5;
    localparam logic [3:0] KIND_DROPPED = 4'd6;
    localparam logic [3:0] KIND_CLOSED  = 4'd7;
    localparam logic [3:0] KIND_FULL    = 4'd8;

    localparam logic [1:0] PHASE_IDLE   = 2'd0;
    localparam logic [1:0] PHASE_OPEN   = 2'd1;
    localparam logic [1:0] PHASE_CLOSED = 2'd2;

    localparam logic [1:0] CFG_BASE    = 2'd0;
    localparam logic [1:0] CFG_RETRIES = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;

    typedef struct packed {
        logic [15:0] tag;
        logic [31:0] seq;
        logic [39:0] deadline;
        logic [2:0]  retries;
    } entry_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] tag;
        logic [31:0] seq;
        logic        last;
    } result_t;
endpackage

[sv/reliable_delivery_retry_tracker.sv]
// Retry tracker top level: entry memory scanned by a sequencer.
//   channel   dir  tdata                                      tuser
//   s_axis    in   func, now_ms, msg_tag, has_tag, rx_seq     -
//   m_axis    out  kind, out_tag, out_seq                     tlast = last
//   cfg       in   cfg_we, cfg_index, cfg_data                -
// Send: the search reads one entry per cycle while the output register is free, then the write.
// Ack: the search, then a read of the hit entry.
// Tick: one memory read per entry and a write-back of each due entry with retries left, then
//   the heartbeat check; a close that follows resends goes out after the held result.
// Other items go through the final step only; data that is delivered goes through a second output step.
// A due entry's result waits in a holding register until the next one is found, so its last flag is known;
//   while the output register waits the sequencer stalls. Reset clears control at once.
`include "reliable_delivery_retry_tracker_macros.svh"
module reliable_delivery_retry_tracker #(
    parameter int TABLE_DEPTH     = 16,
    parameter int MAX_DELAY_SHIFT = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[2:0], now_ms[42:3], msg_tag[58:43], has_tag[59], rx_seq[91:60], zero pad
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // kind[3:0], out_tag[19:4], out_seq[51:20], zero pad
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_PROC  = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_EMIT2 = 3'd4;

    logic [15:0] base_reg;
    logic [2:0]  maxr_reg;
    logic [19:0] tmo_reg;

    logic [2:0]  state_reg;
    logic [2:0]  func_reg;
    logic [39:0] now_reg;
    logic [15:0] tag_reg;
    logic        hastag_reg;
    logic [31:0] rseq_reg;

    rdrt_pkg::entry_t mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    rdrt_pkg::entry_t rd_reg;
    logic [CW-1:0] idx_reg;      // entry whose read data is in rd_reg
    logic [CW-1:0] hit_reg;      // found tag / first free, DEPTH_C = none
    logic [CW-1:0] free_reg;
    logic [31:0] nseq_reg, lin_reg;
    logic [39:0] lpong_reg;
    logic [1:0]  phase_reg;
    logic        emitted_reg;
    logic [IW-1:0] rd_addr;
    logic        rd_en;

    rdrt_pkg::result_t out_reg;
    logic        ovalid_reg;
    rdrt_pkg::result_t pend_reg;  // held tick result or second result of a data item

    logic        wr_en;
    logic [IW-1:0] wr_addr;
    rdrt_pkg::entry_t wr_data;

    logic open_w;
    logic oslot;
    logic [IW-1:0] cur;
    logic due;
    logic [3:0] sh;
    logic [39:0] dly;
    logic dup;

    assign open_w = (phase_reg == rdrt_pkg::PHASE_OPEN);
    assign oslot = !ovalid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = {4'd0, out_reg.seq, out_reg.tag, out_reg.kind};
    assign m_axis_tlast = out_reg.last;
    assign cur = idx_reg[IW-1:0];
    assign due = valid_reg[cur] && (now_reg >= rd_reg.deadline);
    assign sh = ({1'b0, rd_reg.retries} + 4'd1 > 4'(MAX_DELAY_SHIFT)) ?
                4'(MAX_DELAY_SHIFT) : {1'b0, rd_reg.retries} + 4'd1;
    assign dly = {24'd0, base_reg} << sh;
    assign dup = (rseq_reg <= lin_reg);

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= 16'd2000;
            maxr_reg <= 3'd5;
            tmo_reg <= 20'd15000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rdrt_pkg::CFG_BASE:    base_reg <= cfg_data[15:0];
                rdrt_pkg::CFG_RETRIES: maxr_reg <= cfg_data[2:0];
                rdrt_pkg::CFG_TIMEOUT: tmo_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        rd_en = 1'b0;
        rd_addr = '0;
        wr_en = 1'b0;
        wr_addr = cur;
        wr_data = rd_reg;
        if (state_reg == S_IDLE && s_axis_tvalid)
        begin
            rd_en = 1'b1;
        end
        else if (state_reg == S_SCAN && oslot)
        begin
            rd_en = (idx_reg + 1'b1 < DEPTH_C);
            rd_addr = IW'(idx_reg + 1'b1);
            if (func_reg == rdrt_pkg::FUNC_TICK && open_w && due &&
                rd_reg.retries < maxr_reg)
            begin
                wr_en = 1'b1;
                wr_data.deadline = 40'(now_reg + dly);
                wr_data.retries = rd_reg.retries + 3'd1;
            end
        end
        else if (state_reg == S_PROC && hit_reg != DEPTH_C)
        begin
            if (func_reg == rdrt_pkg::FUNC_SEND)
            begin
                wr_en = 1'b1;
                wr_addr = hit_reg[IW-1:0];
                wr_data.tag = tag_reg;
                wr_data.seq = nseq_reg + 32'd1;
                wr_data.deadline = 40'(now_reg + {24'd0, base_reg});
                wr_data.retries = 3'd0;
            end
            else
            begin
                rd_en = 1'b1;
                rd_addr = hit_reg[IW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            nseq_reg <= '0;
            lin_reg <= '0;
            lpong_reg <= '0;
            phase_reg <= rdrt_pkg::PHASE_IDLE;
            ovalid_reg <= 1'b0;
            emitted_reg <= 1'b0;
            idx_reg <= '0;
            hit_reg <= '0;
            free_reg <= '0;
            func_reg <= '0;
            now_reg <= '0;
            tag_reg <= '0;
            hastag_reg <= 1'b0;
            rseq_reg <= '0;
            out_reg <= '0;
            pend_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    ovalid_reg <= ovalid_reg && !m_axis_tready;
                    if (s_axis_tvalid)
                    begin
                        func_reg <= s_axis_tdata[2:0];
                        now_reg <= s_axis_tdata[42:3];
                        tag_reg <= s_axis_tdata[58:43];
                        hastag_reg <= s_axis_tdata[59];
                        rseq_reg <= s_axis_tdata[91:60];
                        idx_reg <= '0;
                        hit_reg <= DEPTH_C;
                        free_reg <= DEPTH_C;
                        emitted_reg <= 1'b0;
                        priority case (s_axis_tdata[2:0])
                            rdrt_pkg::FUNC_SEND, rdrt_pkg::FUNC_TICK,
                            rdrt_pkg::FUNC_ACK: state_reg <= S_SCAN;
                            default: state_reg <= S_FIN;
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (oslot)
                    begin
                        if (func_reg == rdrt_pkg::FUNC_TICK)
                        begin
                            if (open_w && due)
                            begin
                                // hold the new result, release the one held before
                                pend_reg <= {(rd_reg.retries >= maxr_reg) ?
                                    rdrt_pkg::KIND_DROPPED : rdrt_pkg::KIND_RESEND,
                                    rd_reg.tag, rd_reg.seq, 1'b0};
                                out_reg <= pend_reg;
                                ovalid_reg <= emitted_reg;
                                emitted_reg <= 1'b1;
                                if (rd_reg.retries >= maxr_reg)
                                begin
                                    valid_reg[cur] <= 1'b0;
                                end
                            end
                            else
                            begin
                                ovalid_reg <= 1'b0;
                            end
                        end
                        else
                        begin
                            ovalid_reg <= 1'b0;
                            if (valid_reg[cur] && rd_reg.tag == tag_reg &&
                                hit_reg == DEPTH_C)
                            begin
                                hit_reg <= idx_reg;
                            end
                            if (!valid_reg[cur] && free_reg == DEPTH_C)
                            begin
                                free_reg <= idx_reg;
                            end
                        end
                        if (idx_reg + 1'b1 >= DEPTH_C)
                        begin
                            state_reg <= (func_reg == rdrt_pkg::FUNC_TICK) ? S_FIN : S_PROC;
                            if (func_reg == rdrt_pkg::FUNC_SEND)
                            begin
                                if (!(valid_reg[cur] && rd_reg.tag == tag_reg) &&
                                    hit_reg == DEPTH_C)
                                begin
                                    hit_reg <= (free_reg != DEPTH_C) ? free_reg :
                                        (!valid_reg[cur] ? idx_reg : DEPTH_C);
                                end
                            end
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                S_PROC:
                begin
                    if (func_reg == rdrt_pkg::FUNC_SEND)
                    begin
                        if (oslot)
                        begin
                            out_reg.tag <= tag_reg;
                            out_reg.last <= 1'b1;
                            if (hit_reg == DEPTH_C)
                            begin
                                out_reg.kind <= rdrt_pkg::KIND_FULL;
                                out_reg.seq <= '0;
                                ovalid_reg <= 1'b1;
                            end
                            else
                            begin
                                nseq_reg <= nseq_reg + 32'd1;
                                valid_reg[hit_reg[IW-1:0]] <= 1'b1;
                                out_reg.kind <= rdrt_pkg::KIND_SEND;
                                out_reg.seq <= nseq_reg + 32'd1;
                                ovalid_reg <= open_w;
                            end
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        // ack: fetch the hit entry, emit in the final step
                        ovalid_reg <= ovalid_reg && !m_axis_tready;
                        idx_reg <= hit_reg;
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (oslot)
                    begin
                        priority case (func_reg)
                            rdrt_pkg::FUNC_START:
                            begin
                                if (phase_reg == rdrt_pkg::PHASE_IDLE)
                                begin
                                    phase_reg <= rdrt_pkg::PHASE_OPEN;
                                    lpong_reg <= now_reg;
                                end
                                ovalid_reg <= 1'b0;
                                state_reg <= S_IDLE;
                            end
                            rdrt_pkg::FUNC_TICK:
                            begin
                                if (open_w && now_reg > lpong_reg &&
                                    now_reg - lpong_reg > {20'd0, tmo_reg})
                                begin
                                    phase_reg <= rdrt_pkg::PHASE_CLOSED;
                                    ovalid_reg <= 1'b1;
                                    if (emitted_reg)
                                    begin
                                        // the held result goes first, the close follows
                                        out_reg <= pend_reg;
                                        pend_reg <= {rdrt_pkg::KIND_CLOSED, 16'd0, 32'd0, 1'b1};
                                        state_reg <= S_EMIT2;
                                    end
                                    else
                                    begin
                                        out_reg <= {rdrt_pkg::KIND_CLOSED, 16'd0, 32'd0, 1'b1};
                                        state_reg <= S_IDLE;
                                    end
                                end
                                else
                                begin
                                    // release the held result as the final one
                                    out_reg <= {pend_reg.kind, pend_reg.tag, pend_reg.seq, 1'b1};
                                    ovalid_reg <= emitted_reg;
                                    state_reg <= S_IDLE;
                                end
                            end
                            rdrt_pkg::FUNC_ACK:
                            begin
                                if (open_w && idx_reg != DEPTH_C)
                                begin
                                    valid_reg[cur] <= 1'b0;
                                end
                                out_reg <= {rdrt_pkg::KIND_ACKED, rd_reg.tag, rd_reg.seq, 1'b1};
                                ovalid_reg <= open_w && idx_reg != DEPTH_C;
                                state_reg <= S_IDLE;
                            end
                            rdrt_pkg::FUNC_PONG:
                            begin
                                if (open_w)
                                begin
                                    lpong_reg <= now_reg;
                                end
                                ovalid_reg <= 1'b0;
                                state_reg <= S_IDLE;
                            end
                            rdrt_pkg::FUNC_PING:
                            begin
                                out_reg <= {rdrt_pkg::KIND_PONG, 16'd0, 32'd0, 1'b1};
                                ovalid_reg <= open_w;
                                state_reg <= S_IDLE;
                            end
                            rdrt_pkg::FUNC_DATA:
                            begin
                                if (open_w)
                                begin
                                    pend_reg <= {rdrt_pkg::KIND_DELIVER,
                                        hastag_reg ? tag_reg : 16'd0, rseq_reg, 1'b1};
                                    out_reg <= {rdrt_pkg::KIND_ACK, tag_reg, rseq_reg, dup};
                                    if (rseq_reg != 32'd0 && !dup)
                                    begin
                                        lin_reg <= rseq_reg;
                                    end
                                    // ack only sequenced data with a tag; duplicates are acked but not delivered
                                    ovalid_reg <= (rseq_reg != 32'd0) && hastag_reg;
                                    state_reg <= (rseq_reg != 32'd0 && dup) ? S_IDLE : S_EMIT2;
                                end
                                else
                                begin
                                    ovalid_reg <= 1'b0;
                                    state_reg <= S_IDLE;
                                end
                            end
                            default:
                            begin
                                ovalid_reg <= 1'b0;
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_EMIT2:
                begin
                    if (oslot)
                    begin
                        out_reg <= pend_reg;
                        ovalid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    ovalid_reg <= ovalid_reg && !m_axis_tready;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `RDRT_ASSERT(a_busy_no_ready, clk, rst_n, (state_reg != S_IDLE) |-> !s_axis_tready)
    `RDRT_ASSERT(a_out_hold, clk, rst_n, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    `RDRT_ASSERT(a_closed_stays, clk, rst_n,
        (phase_reg == rdrt_pkg::PHASE_CLOSED) |=> (phase_reg == rdrt_pkg::PHASE_CLOSED))
    `RDRT_ASSERT_RST(a_reset_idle, clk, !rst_n |-> (state_reg == S_IDLE))
endmodule
